@@ hw/rtl/tcnb_pkg.sv @@
// ---------------------------------------------------------------------------
// tcnb_pkg: shared types and constants
// Widths, status codes and the sequencer state type for the centroid block.
// ---------------------------------------------------------------------------
package tcnb_pkg;
   localparam int MAX_TRI     = 4096;
   localparam int IDX_W       = 12;
   localparam int CNT_W       = 13;
   localparam int SUM_W       = 34;
   localparam int TOT_W       = 46;
   localparam int FRAC_BITS   = 16;
   localparam int SCALE_FRAC  = 24;
   localparam int NUM_REGS    = 6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_EXTENT   = 2'd2;
   localparam logic [1:0] ST_PAST_END = 2'd3;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_SCAN = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_PREP, S_DIV, S_SCALE, S_READ, S_MUL, S_DIV3, S_OUT
   } state_type;

   typedef struct packed {
      logic [31:0] cx, cy, cz;
      logic        in_box;
      logic [11:0] idx;
      logic [12:0] kept;
      logic        last;
      logic [1:0]  status;
   } rsp_type;
endpackage

@@ hw/rtl/tcnb_if.sv @@
// ---------------------------------------------------------------------------
// tcnb channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ---------------------------------------------------------------------------
interface tcnb_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] vert1_x, vert1_y, vert1_z;
   logic [31:0] vert2_x, vert2_y, vert2_z;
   logic [31:0] vert3_x, vert3_y, vert3_z;
   modport source (output valid, req_type, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y,
                   vert2_z, vert3_x, vert3_y, vert3_z, input ready);
   modport sink (input valid, req_type, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y,
                 vert2_z, vert3_x, vert3_y, vert3_z, output ready);
endinterface

interface tcnb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] centroid_x, centroid_y, centroid_z;
   logic        inside_box;
   logic [11:0] triangle_index;
   logic [12:0] kept_total;
   logic        last_of_set;
   logic [1:0]  status_code;
   modport source (output valid, centroid_x, centroid_y, centroid_z, inside_box,
                   triangle_index, kept_total, last_of_set, status_code, input ready);
   modport sink (input valid, centroid_x, centroid_y, centroid_z, inside_box,
                 triangle_index, kept_total, last_of_set, status_code, output ready);
endinterface

interface tcnb_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tcnb_divider.sv @@
// ---------------------------------------------------------------------------
// tcnb_divider: unsigned restoring divider
// One quotient bit per cycle, 64-bit dividend over a 48-bit divisor.
// ---------------------------------------------------------------------------
module tcnb_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [47:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff, q_in;
   logic [48:0] r_ff, r_in;
   logic [47:0] d_ff, d_in;
   logic [6:0]  n_ff, n_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [48:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[47:0], q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; n_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[48]) begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[47:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = n_ff - 7'd1;
         if (n_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

@@ hw/rtl/triangle_centroid_normalize_box_select_unit.sv @@
// ---------------------------------------------------------------------------
// triangle_centroid_normalize_box_select_unit: centroid normalize and box test
// Stores per-triangle vertex sums, then scans them out normalized.
// ---------------------------------------------------------------------------
// Load: accept, then one memory write and total/max update.
// Scan: accept, memory read, scale multiply, divide by three through a
//   reciprocal multiply, box test, result transfer; empty set and scan past
//   end skip the memory read and arithmetic, nonpositive extent skips the
//   multiply and divide. The first scan of a set also runs three center
//   divisions and one scale division (no scale division for a nonpositive
//   extent) on one shared bit-serial divider.
// Reset: synchronous, clears control state; the sum memory is not cleared and
//   no entry is read before it is written in the current set.
module triangle_centroid_normalize_box_select_unit (
   input logic clock,
   input logic reset,
   tcnb_req_if.sink   req,
   tcnb_rsp_if.source rsp,
   tcnb_csr_if.sink   csr
);
   // sum memory: x, y, z sums of one triangle per entry
   logic [3*tcnb_pkg::SUM_W-1:0] sum_mem [tcnb_pkg::MAX_TRI];
   logic [3*tcnb_pkg::SUM_W-1:0] rd_data_ff;

   logic signed [31:0] box_ff [tcnb_pkg::NUM_REGS];

   tcnb_pkg::state_type state_ff, state_in;

   logic signed [tcnb_pkg::TOT_W-1:0] tot_ff [3];
   logic signed [tcnb_pkg::SUM_W-1:0] max_ff [3];
   logic signed [tcnb_pkg::SUM_W-1:0] lsum_ff [3];
   logic [tcnb_pkg::CNT_W-1:0] count_ff, ptr_ff, kept_ff;
   logic scanning_ff, extent_ff, full_ff;
   logic signed [31:0] center_ff [3];
   logic [31:0] scale_ff;
   logic [1:0]  step_ff;              // which division is running
   logic [63:0] prod_ff [3];          // |d| * scale
   logic        ovf_ff [3];
   logic        neg_ff [3];
   logic [31:0] mag_ff [3];           // |d| * scale / (3 * 2^24), clipped
   tcnb_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff;

   // csr: always ready; registers are to be written only while idle, which the block does not enforce
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tcnb_pkg::NUM_REGS; i++) box_ff[i] <= '0;
      end else if (csr.valid && csr.index < 3'(tcnb_pkg::NUM_REGS)) begin
         box_ff[csr.index] <= csr.data;
      end
   end

   // shared divider for the centers and the scale
   logic        div_start, div_done;
   logic [63:0] div_num, div_q;
   logic [47:0] div_den;
   logic signed [tcnb_pkg::SUM_W-1:0] mx;

   tcnb_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      mx = max_ff[0];
      if (max_ff[1] > mx) mx = max_ff[1];
      if (max_ff[2] > mx) mx = max_ff[2];
   end

   // centers start from S_PREP, the scale starts from the last S_DIV cycle
   logic signed [tcnb_pkg::TOT_W-1:0] tot_sel;
   logic [tcnb_pkg::TOT_W-1:0] tot_mag;
   always_comb begin
      tot_sel = tot_ff[step_ff];
      tot_mag = tot_sel[tcnb_pkg::TOT_W-1] ? tcnb_pkg::TOT_W'(-tot_sel)
                                            : tcnb_pkg::TOT_W'(tot_sel);
      if (state_ff == tcnb_pkg::S_DIV) begin
         div_num = 64'd3 << (tcnb_pkg::FRAC_BITS + tcnb_pkg::SCALE_FRAC - 2);
         div_den = 48'(mx);
      end else begin
         div_num = 64'(tot_mag);
         div_den = 48'(count_ff) * 48'd3;
      end
   end

   // next state
   logic is_load, is_scan, req_acc;
   assign req.ready = (state_ff == tcnb_pkg::S_IDLE) && !rsp_valid_ff;
   assign req_acc   = req.valid && req.ready;
   assign is_load   = req_acc && req.req_type == tcnb_pkg::REQ_LOAD;
   assign is_scan   = req_acc && req.req_type == tcnb_pkg::REQ_SCAN;

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      case (state_ff)
         tcnb_pkg::S_IDLE: begin
            if (is_load) state_in = tcnb_pkg::S_LOAD;
            else if (is_scan) begin
               if (count_ff == '0 || (scanning_ff && ptr_ff >= count_ff))
                  state_in = tcnb_pkg::S_OUT;
               else if (!scanning_ff) state_in = tcnb_pkg::S_PREP;
               else state_in = tcnb_pkg::S_READ;
            end
         end
         tcnb_pkg::S_LOAD: state_in = tcnb_pkg::S_IDLE;
         tcnb_pkg::S_PREP: begin
            div_start = 1'b1;
            state_in = tcnb_pkg::S_DIV;
         end
         tcnb_pkg::S_DIV: begin
            if (div_done) begin
               if (step_ff == 2'd2) begin
                  if (mx <= 0) state_in = tcnb_pkg::S_READ;
                  else begin
                     div_start = 1'b1;
                     state_in = tcnb_pkg::S_SCALE;
                  end
               end else state_in = tcnb_pkg::S_PREP;
            end
         end
         tcnb_pkg::S_SCALE: if (div_done) state_in = tcnb_pkg::S_READ;
         tcnb_pkg::S_READ:  state_in = extent_ff ? tcnb_pkg::S_MUL : tcnb_pkg::S_OUT;
         tcnb_pkg::S_MUL:   state_in = tcnb_pkg::S_DIV3;
         tcnb_pkg::S_DIV3:  state_in = tcnb_pkg::S_OUT;
         tcnb_pkg::S_OUT:   state_in = tcnb_pkg::S_IDLE;
         default:           state_in = tcnb_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tcnb_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   // load path: sums in the accept cycle, store and accumulate the next
   logic signed [tcnb_pkg::SUM_W-1:0] s_new [3];
   always_comb begin
      s_new[0] = tcnb_pkg::SUM_W'($signed(req.vert1_x)) + tcnb_pkg::SUM_W'($signed(req.vert2_x))
               + tcnb_pkg::SUM_W'($signed(req.vert3_x));
      s_new[1] = tcnb_pkg::SUM_W'($signed(req.vert1_y)) + tcnb_pkg::SUM_W'($signed(req.vert2_y))
               + tcnb_pkg::SUM_W'($signed(req.vert3_y));
      s_new[2] = tcnb_pkg::SUM_W'($signed(req.vert1_z)) + tcnb_pkg::SUM_W'($signed(req.vert2_z))
               + tcnb_pkg::SUM_W'($signed(req.vert3_z));
   end

   always_ff @(posedge clock) begin
      if (is_load) for (int k = 0; k < 3; k++) lsum_ff[k] <= s_new[k];
      if (state_ff == tcnb_pkg::S_LOAD && !full_ff)
         sum_mem[count_ff[tcnb_pkg::IDX_W-1:0]] <= {lsum_ff[2], lsum_ff[1], lsum_ff[0]};
      if (state_in == tcnb_pkg::S_READ)
         rd_data_ff <= sum_mem[ptr_ff[tcnb_pkg::IDX_W-1:0]];
   end

   // normalize per axis
   logic signed [tcnb_pkg::SUM_W+1:0] d_ax [3];
   logic [tcnb_pkg::SUM_W+1:0] dmag [3];
   logic [tcnb_pkg::SUM_W-1:0] rs [3];
   logic [67:0] prod_full [3];
   assign rs[0] = rd_data_ff[tcnb_pkg::SUM_W-1:0];
   assign rs[1] = rd_data_ff[2*tcnb_pkg::SUM_W-1:tcnb_pkg::SUM_W];
   assign rs[2] = rd_data_ff[3*tcnb_pkg::SUM_W-1:2*tcnb_pkg::SUM_W];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_ax[k] = (tcnb_pkg::SUM_W+2)'($signed(rs[k]))
                 - (tcnb_pkg::SUM_W+2)'(center_ff[k]) * 3;
         dmag[k] = d_ax[k][tcnb_pkg::SUM_W+1] ? (tcnb_pkg::SUM_W+2)'(-d_ax[k])
                                              : (tcnb_pkg::SUM_W+2)'(d_ax[k]);
         prod_full[k] = 68'(dmag[k]) * 68'(scale_ff);
      end
   end

   // product / (3 * 2^24): shift, then reciprocal of 3 on a 34-bit part;
   // anything at or above 3 * 2^32 after the shift saturates anyway
   logic [39:0] hi [3];
   logic        big [3];
   logic [66:0] recip [3];
   logic [32:0] qq [3];
   logic [34:0] rem [3];
   logic [32:0] qf [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hi[k]    = prod_ff[k][63:24];
         big[k]   = hi[k] >= 40'h3_0000_0000;
         recip[k] = 67'(hi[k][33:0]) * 67'h1_5555_5555;
         qq[k]    = recip[k][66:34];
         rem[k]   = 35'(hi[k][33:0]) - 35'(qq[k]) * 35'd3;
         qf[k]    = (rem[k] >= 35'd3) ? qq[k] + 33'd1 : qq[k];
      end
   end

   logic signed [31:0] cen [3];
   logic ins;
   always_comb begin
      ins = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if (neg_ff[k]) cen[k] = ovf_ff[k] || mag_ff[k][31] ? 32'sh80000000
                                                            : -$signed(mag_ff[k]);
         else cen[k] = ovf_ff[k] || mag_ff[k][31] ? 32'sh7fffffff : $signed(mag_ff[k]);
         if (cen[k] < box_ff[2*k] || cen[k] > box_ff[2*k+1]) ins = 1'b0;
      end
   end

   // a scan that reached the box test
   logic out_ok;
   assign out_ok = (state_ff == tcnb_pkg::S_OUT) && (rsp_ff.status == tcnb_pkg::ST_OK);

   logic [63:0] qsat;
   assign qsat = div_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; ptr_ff <= '0; kept_ff <= '0; scanning_ff <= 1'b0;
         extent_ff <= 1'b0; full_ff <= 1'b0; rsp_valid_ff <= 1'b0; step_ff <= '0;
         scale_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            tot_ff[k] <= '0; max_ff[k] <= '0; center_ff[k] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (is_load) begin
            if (scanning_ff) begin
               count_ff <= '0; ptr_ff <= '0; kept_ff <= '0; scanning_ff <= 1'b0;
               extent_ff <= 1'b0; scale_ff <= '0; full_ff <= 1'b0;
               for (int k = 0; k < 3; k++) begin
                  tot_ff[k] <= '0; center_ff[k] <= '0;
               end
            end else full_ff <= count_ff >= tcnb_pkg::CNT_W'(tcnb_pkg::MAX_TRI);
         end
         if (state_ff == tcnb_pkg::S_LOAD && !full_ff) begin
            for (int k = 0; k < 3; k++) begin
               tot_ff[k] <= tot_ff[k] + tcnb_pkg::TOT_W'(lsum_ff[k]);
               if (count_ff == '0 || lsum_ff[k] > max_ff[k]) max_ff[k] <= lsum_ff[k];
            end
            count_ff <= count_ff + 1'b1;
         end
         if (is_scan && !scanning_ff) step_ff <= '0;
         if (state_ff == tcnb_pkg::S_DIV && div_done) begin
            if (tot_sel < 0)
               center_ff[step_ff] <= (div_q >= 64'h80000000) ? 32'sh80000000
                                                             : -$signed(div_q[31:0]);
            else
               center_ff[step_ff] <= (div_q > 64'h7fffffff) ? 32'sh7fffffff
                                                            : $signed(div_q[31:0]);
            if (step_ff == 2'd2) begin
               extent_ff <= mx > 0;
               step_ff <= 2'd3;
            end else step_ff <= step_ff + 2'd1;
         end
         if (state_ff == tcnb_pkg::S_SCALE && div_done)
            scale_ff <= (qsat > 64'hffffffff) ? 32'hffffffff : qsat[31:0];
         if (is_scan) scanning_ff <= 1'b1;
         if (state_ff == tcnb_pkg::S_OUT) rsp_valid_ff <= 1'b1;
         if (state_ff == tcnb_pkg::S_READ) ptr_ff <= ptr_ff + 1'b1;
         if (out_ok && ins) kept_ff <= kept_ff + 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == tcnb_pkg::S_MUL) begin
         for (int k = 0; k < 3; k++) begin
            neg_ff[k] <= d_ax[k][tcnb_pkg::SUM_W+1];
            // |d| * scale above 2^62 saturates
            ovf_ff[k] <= prod_full[k] > 68'h4000000000000000;
            prod_ff[k] <= prod_full[k][63:0];
         end
      end
      if (state_ff == tcnb_pkg::S_DIV3) begin
         for (int k = 0; k < 3; k++) begin
            ovf_ff[k] <= ovf_ff[k] || big[k] || qf[k][32];
            mag_ff[k] <= qf[k][31:0];
         end
      end
   end

   // response capture
   always_comb begin
      rsp_in = rsp_ff;
      if (is_scan) begin
         rsp_in = '0;
         rsp_in.kept = kept_ff;
         if (count_ff == '0) rsp_in.status = tcnb_pkg::ST_EMPTY;
         else if (scanning_ff && ptr_ff >= count_ff) rsp_in.status = tcnb_pkg::ST_PAST_END;
      end
      if (state_ff == tcnb_pkg::S_READ) begin
         rsp_in.idx    = ptr_ff[tcnb_pkg::IDX_W-1:0];
         rsp_in.last   = (ptr_ff + 1'b1) == count_ff;
         rsp_in.status = extent_ff ? tcnb_pkg::ST_OK : tcnb_pkg::ST_EXTENT;
         rsp_in.kept   = kept_ff;
      end
      if (out_ok) begin
         rsp_in.cx = cen[0]; rsp_in.cy = cen[1]; rsp_in.cz = cen[2];
         rsp_in.in_box = ins;
         rsp_in.kept = kept_ff + tcnb_pkg::CNT_W'(ins);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.centroid_x     = rsp_ff.cx;
   assign rsp.centroid_y     = rsp_ff.cy;
   assign rsp.centroid_z     = rsp_ff.cz;
   assign rsp.inside_box     = rsp_ff.in_box;
   assign rsp.triangle_index = rsp_ff.idx;
   assign rsp.kept_total     = rsp_ff.kept;
   assign rsp.last_of_set    = rsp_ff.last;
   assign rsp.status_code    = rsp_ff.status;
endmodule

@@ dv/tcnb_test_if.sv @@
// ---------------------------------------------------------------------------
// tcnb test channel note
// The channel interfaces come from the RTL; this file only carries the
// request item type that the test uses to build and predict transfers.
// ---------------------------------------------------------------------------
package tcnb_test_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        kind;
      logic [31:0] v[9];
   } tri_item_type;
endpackage

@@ dv/triangle_centroid_normalize_box_select_unit_test.sv @@
// ---------------------------------------------------------------------------
// triangle_centroid_normalize_box_select_unit_test: self-checking testbench
// Drives load and scan transfers with bursty timing, predicts every scan
// result with a local model of the block and compares all fields at once.
// ---------------------------------------------------------------------------
module triangle_centroid_normalize_box_select_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tcnb_pkg::*;
   import tcnb_test_pkg::*;

   localparam longint LIMIT_CYCLES = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcnb_req_if req ();
   tcnb_rsp_if rsp ();
   tcnb_csr_if csr ();

   triangle_centroid_normalize_box_select_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---- predictor state -------------------------------------------------
   longint     sum_mem[3][MAX_TRI];
   longint     axis_total[3];
   longint     axis_max[3];
   int         n_tri, scan_ptr, kept_n;
   longint     center[3];
   longint     scale_q;
   bit         in_scan, extent_pos;
   longint     box[6];

   rsp_type    centroid_q[$];
   int         fail_count = 0;
   bit         hold_off = 1'b0;
   longint     cycle_count = 0;

   function automatic longint clamp32(bit neg, longint unsigned m);
      if (neg) return (m >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(m);
      return (m > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(m);
   endfunction

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint norm_axis(longint s, longint c);
      longint          d;
      longint unsigned m;
      d = s - 3 * c;
      m = abs64(d);
      if (scale_q == 0 || m == 0) return 0;
      if (m > (64'd1 << 62) / longint'(scale_q)) return clamp32(d < 0, 64'h1_0000_0000);
      m = m * longint'(scale_q) / (64'd3 << SCALE_FRAC);
      return clamp32(d < 0, m);
   endfunction

   function automatic void clear_set();
      for (int k = 0; k < 3; k++) begin
         axis_total[k] = 0; axis_max[k] = 0; center[k] = 0;
      end
      n_tri = 0; scan_ptr = 0; kept_n = 0;
      scale_q = 0; in_scan = 0; extent_pos = 0;
   endfunction

   function automatic void prepare_scan();
      longint          mx;
      longint unsigned q;
      for (int k = 0; k < 3; k++)
         center[k] = clamp32(axis_total[k] < 0,
                             abs64(axis_total[k]) / (64'd3 * longint'(n_tri)));
      mx = axis_max[0];
      if (axis_max[1] > mx) mx = axis_max[1];
      if (axis_max[2] > mx) mx = axis_max[2];
      if (mx <= 0) begin
         extent_pos = 0; scale_q = 0;
         return;
      end
      extent_pos = 1;
      q = (64'd3 << (FRAC_BITS + SCALE_FRAC - 2)) / mx;
      scale_q = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
   endfunction

   // Applies one accepted item to the model, queues a result for scans.
   function automatic void predict_centroid(tri_item_type it);
      rsp_type r;
      longint  s[3], c;
      bit      ins;
      if (it.kind == REQ_LOAD) begin
         if (in_scan) clear_set();
         if (n_tri >= MAX_TRI) return;
         for (int k = 0; k < 3; k++) begin
            s[k] = longint'($signed(it.v[k])) + longint'($signed(it.v[3 + k]))
                 + longint'($signed(it.v[6 + k]));
            sum_mem[k][n_tri] = s[k];
            axis_total[k] += s[k];
            if (n_tri == 0 || s[k] > axis_max[k]) axis_max[k] = s[k];
         end
         n_tri++;
         return;
      end
      r = '0;
      r.kept = kept_n[12:0];
      if (n_tri == 0) begin
         in_scan = 1; r.status = ST_EMPTY;
      end else begin
         if (!in_scan) begin
            prepare_scan(); in_scan = 1;
         end
         if (scan_ptr >= n_tri) r.status = ST_PAST_END;
         else begin
            r.idx = scan_ptr[11:0];
            r.last = (scan_ptr + 1 == n_tri);
            if (!extent_pos) r.status = ST_EXTENT;
            else begin
               ins = 1;
               for (int k = 0; k < 3; k++) begin
                  c = norm_axis(sum_mem[k][scan_ptr], center[k]);
                  if (c < box[2 * k] || c > box[2 * k + 1]) ins = 0;
                  if (k == 0) r.cx = c[31:0];
                  if (k == 1) r.cy = c[31:0];
                  if (k == 2) r.cz = c[31:0];
               end
               if (ins) kept_n++;
               r.in_box = ins; r.kept = kept_n[12:0]; r.status = ST_OK;
            end
            scan_ptr++;
         end
      end
      centroid_q = {centroid_q, r};
   endfunction

   // ---- drivers ----------------------------------------------------------
   int burst_left = 0;

   // valid stays up between items of a burst; send_set drops it at the end
   task automatic send_item(tri_item_type it);
      int gap;
      // sender bursts: random gap before a new burst
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.req_type <= it.kind;
      {req.vert1_x, req.vert1_y, req.vert1_z, req.vert2_x, req.vert2_y, req.vert2_z,
       req.vert3_x, req.vert3_y, req.vert3_z} <= {it.v[0], it.v[1], it.v[2], it.v[3],
       it.v[4], it.v[5], it.v[6], it.v[7], it.v[8]};
      do @(posedge clock); while (!req.ready);
      predict_centroid(it);
      @(negedge clock);
   endtask

   task automatic write_reg(int idx, logic [31:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx[2:0];
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      box[idx] = longint'($signed(val));
      @(negedge clock);
   endtask

   // Waits for every expected result plus the scan latency.
   task automatic drain();
      while (centroid_q.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic set_box(longint lo, longint hi);
      drain();
      for (int i = 0; i < 6; i++) write_reg(i, (i % 2) ? hi[31:0] : lo[31:0]);
      csr.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 2) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
      endcase
   endfunction

   function automatic tri_item_type make_tri(logic kind, int mode);
      tri_item_type it;
      it.kind = kind;
      for (int i = 0; i < 9; i++) it.v[i] = (kind == REQ_SCAN) ? $urandom() : rand_coord(mode);
      return it;
   endfunction

   task automatic send_set(int n_load, int n_scan, int mode);
      for (int i = 0; i < n_load; i++) send_item(make_tri(REQ_LOAD, mode));
      for (int i = 0; i < n_scan; i++) send_item(make_tri(REQ_SCAN, mode));
      req.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
   endtask

   // ---- checker and receiver --------------------------------------------
   int stall_phase = 0;

   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      rsp.ready <= !hold_off && !(stall_phase % 7 == 3 || ($urandom_range(0, 9) == 0));
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) cycle_count <= cycle_count + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         if (centroid_q.size() == 0) begin
            $display("%0t: unexpected result idx=%0d", $realtime, rsp.triangle_index);
            fail_count++;
         end else begin
            e = centroid_q.pop_front();
            if ({rsp.centroid_x, rsp.centroid_y, rsp.centroid_z, rsp.inside_box,
                 rsp.triangle_index, rsp.kept_total, rsp.last_of_set,
                 rsp.status_code} !== e) begin
               $display("%0t: mismatch expected cx=%h cy=%h cz=%h in=%b idx=%0d kept=%0d last=%b st=%0d",
                        $realtime, e.cx, e.cy, e.cz, e.in_box, e.idx, e.kept, e.last, e.status);
               $display("%0t:          actual cx=%h cy=%h cz=%h in=%b idx=%0d kept=%0d last=%b st=%0d",
                        $realtime, rsp.centroid_x, rsp.centroid_y, rsp.centroid_z,
                        rsp.inside_box, rsp.triangle_index, rsp.kept_total,
                        rsp.last_of_set, rsp.status_code);
               fail_count++;
            end
         end
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---- tests ------------------------------------------------------------
   task automatic test_empty_and_extremes();
      send_item(make_tri(REQ_SCAN, 0));          // empty set
      send_item(make_tri(REQ_SCAN, 0));
      send_set(3, 4, 1);                         // extreme coordinates, scan past end
      send_set(2, 2, 0);
   endtask

   task automatic test_nonpositive_extent();
      tri_item_type it;
      it.kind = REQ_LOAD;
      for (int i = 0; i < 9; i++) it.v[i] = 32'hFFFF_0000;   // all sums negative
      send_item(it);
      send_item(it);
      send_set(0, 3, 0);
      for (int i = 0; i < 9; i++) it.v[i] = 32'h0;           // zero extent
      send_item(it);
      send_set(0, 2, 0);
   endtask

   task automatic test_box_settings();
      set_box(-64'sd2147483648, 64'sd2147483647);            // everything kept
      send_set(4, 4, 2);
      set_box(64'sd0, 64'sd0);
      send_set(3, 3, 2);
      set_box(-64'sd49152, 64'sd49152);
      send_set(5, 5, 2);
   endtask

   task automatic test_random_sets(int items);
      int sent, nl, ns;
      sent = 0;
      while (sent < items) begin
         nl = $urandom_range(1, 12);
         ns = nl + $urandom_range(0, 1);
         if ($urandom_range(0, 9) == 0) ns = $urandom_range(0, nl); // broken scan
         send_set(nl, ns, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2);
         sent += nl + ns;
         if ($urandom_range(0, 40) == 0) begin
            set_box(-64'($urandom_range(0, 32'h0002_0000)),
                    64'($urandom_range(0, 32'h0002_0000)));
         end
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         send_set(6, 40, 2);
      join
   endtask

   initial begin
      req.valid = 1'b0; req.req_type = REQ_LOAD;
      {req.vert1_x, req.vert1_y, req.vert1_z, req.vert2_x, req.vert2_y, req.vert2_z,
       req.vert3_x, req.vert3_y, req.vert3_z} = '0;
      csr.valid = 1'b0; csr.index = '0; csr.data = '0;
      rsp.ready = 1'b0;
      for (int i = 0; i < 6; i++) box[i] = 0;
      clear_set();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_and_extremes();
      test_nonpositive_extent();
      test_box_settings();
      test_backpressure();
      test_random_sets(1850);
      set_box(64'sd2147483647, -64'sd2147483648);            // inverted box: none kept
      send_set(4, 5, 2);
      drain();

      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

@@ triangle_centroid_normalize_box_select_unit.f @@
hw/rtl/tcnb_pkg.sv
hw/rtl/tcnb_if.sv
hw/rtl/tcnb_divider.sv
hw/rtl/triangle_centroid_normalize_box_select_unit.sv
dv/tcnb_test_if.sv
dv/triangle_centroid_normalize_box_select_unit_test.sv
